// ----- src/spq_pkg.sv -----
// spq_pkg: shared types and constants for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
package spq_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DATA_W = 16;
  localparam int PRIO_W = 16;
  localparam int TOTAL_W = 7;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0] item_priority;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  out_data;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] entry_total;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] priority_key;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_ctl_t;

endpackage

// ----- src/spq_cell.sv -----
// spq_cell: one slot of the sorted chain, holds one entry
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic               prev_gt,
  input  logic               prev_ins,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output spq_pkg::entry_t    entry,
  output logic               gt,
  output logic               ins
);

  // strictly greater entries move back so equal keys keep arrival order
  assign gt  = occupied && (entry.priority_key > ctl.item.priority_key);
  assign ins = gt || !occupied;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else if (ins && !prev_ins) begin
        entry <= ctl.item;
      end
    end else if (ctl.pop) begin
      entry <= next_entry;
    end
  end

endmodule

// ----- src/sorted_priority_queue.sv -----
// sorted_priority_queue: top level, a chain of spq_cell slots plus fill count
// depends on spq_pkg and spq_cell
//
// Takes one push or pop request in every cycle (busy stays low) and gives its
// registered result in the next cycle with done high for that single cycle; the
// receiver cannot stall. Each slot compares its key with the pushed key in
// parallel and shifts back, or forward on a pop, in the same cycle, so the
// rate is one transaction per clock at any capacity. A push to a full queue is
// dropped with status full, a pop on an empty queue returns status empty.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  spq_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output spq_pkg::rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       fill_count;
  logic [CW-1:0]       fill_count_next;
  logic [CW+6:0]       total_wide;
  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic                push_go;
  logic                pop_go;
  spq_pkg::cell_ctl_t  ctl;
  spq_pkg::entry_t     entries [CAPACITY];
  logic [CAPACITY-1:0] gts;
  logic [CAPACITY-1:0] inss;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (fill_count == CW'(CAPACITY));
  assign is_empty = (fill_count == '0);
  assign push_go  = accept && (req.req_type == spq_pkg::REQ_PUSH) && !is_full;
  assign pop_go   = accept && (req.req_type == spq_pkg::REQ_POP) && !is_empty;

  assign ctl.push              = push_go;
  assign ctl.pop               = pop_go;
  assign ctl.item.data         = req.item_data;
  assign ctl.item.priority_key = req.item_priority;

  always_comb begin
    fill_count_next = fill_count;
    if (push_go) begin
      fill_count_next = fill_count + CW'(1);
    end else if (pop_go) begin
      fill_count_next = fill_count - CW'(1);
    end
  end

  assign total_wide = {7'd0, fill_count_next};

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      spq_pkg::entry_t prev_e;
      spq_pkg::entry_t next_e;
      logic            p_gt;
      logic            p_ins;

      if (i == 0) begin : g_head
        assign prev_e = entries[i];
        assign p_gt   = 1'b0;
        assign p_ins  = 1'b0;
      end else begin : g_body
        assign prev_e = entries[i-1];
        assign p_gt   = gts[i-1];
        assign p_ins  = inss[i-1];
      end

      // slot past the end reads anything; it is beyond the count after a pop
      if (i == CAPACITY - 1) begin : g_tail
        assign next_e = entries[i];
      end else begin : g_mid
        assign next_e = entries[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (CW'(i) < fill_count),
        .prev_gt    (p_gt),
        .prev_ins   (p_ins),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .entry      (entries[i]),
        .gt         (gts[i]),
        .ins        (inss[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      done       <= accept;
    end
    rsp.entry_total <= total_wide[6:0];
    rsp.out_data    <= pop_go ? entries[0].data : '0;
    if (accept && (req.req_type == spq_pkg::REQ_PUSH) && is_full) begin
      rsp.status <= spq_pkg::STAT_FULL;
    end else if (accept && (req.req_type == spq_pkg::REQ_POP) && is_empty) begin
      rsp.status <= spq_pkg::STAT_EMPTY;
    end else begin
      rsp.status <= spq_pkg::STAT_OK;
    end
  end

endmodule
